@@ src/smpd_pkg.sv @@
// Shared types and constants for the serial mouse packet decoder.
// Holds the byte-position state, the decoder state record and the report word.
// No dependencies.
package smpd_pkg;

    localparam logic [7:0] MIDDLE_PRESS_BYTE   = 8'h20;
    localparam logic [7:0] MIDDLE_RELEASE_BYTE = 8'h00;
    localparam int         START_BIT           = 6;
    localparam int         LEFT_BIT            = 5;
    localparam int         RIGHT_BIT           = 4;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_MIDDLE = 1'b1;

    typedef enum logic [1:0] {
        POS_HUNT   = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2
    } t_pos;

    typedef struct packed {
        logic       right_release;
        logic       left_release;
        logic       right_press;
        logic       left_press;
    } t_flags;

    typedef struct packed {
        t_pos       pos;
        logic [7:0] first_byte;
        logic [5:0] second_low;
        logic       left_down;
        logic       right_down;
        logic [7:0] last_dx;
        logic [7:0] last_dy;
        t_flags     last_flags;
    } t_state;

    localparam t_state STATE_RESET = '{
        pos:        POS_HUNT,
        first_byte: 8'h00,
        second_low: 6'h00,
        left_down:  1'b0,
        right_down: 1'b0,
        last_dx:    8'h00,
        last_dy:    8'h00,
        last_flags: '0
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] dx;
        logic [7:0] dy;
        t_flags     flags;
        logic       middle_press;
        logic       middle_release;
    } t_report;

endpackage

@@ src/smpd_decode.sv @@
// Per-byte decode logic: next decoder state and the report word for one byte.
// Purely combinational; uses smpd_pkg.
module smpd_decode (
    input  logic [7:0]      i_rx_byte,
    input  smpd_pkg::t_state i_state,
    output smpd_pkg::t_state o_next_state,
    output logic            o_emit,
    output smpd_pkg::t_report o_report
);
    import smpd_pkg::*;

    always_comb begin
        logic lp;
        logic rp;
        logic lr;
        logic rr;
        o_next_state = i_state;
        lp = i_state.first_byte[LEFT_BIT];
        rp = i_state.first_byte[RIGHT_BIT];
        lr = 1'b0;
        rr = 1'b0;
        unique case (i_state.pos)
            POS_SECOND: begin
                o_next_state.second_low = i_rx_byte[5:0];
                o_next_state.pos        = POS_THIRD;
            end
            POS_THIRD: begin
                o_next_state.last_dx = {i_state.first_byte[1:0], i_state.second_low};
                o_next_state.last_dy = {i_state.first_byte[3:2], i_rx_byte[5:0]};
                if (lp) begin
                    o_next_state.left_down = 1'b1;
                end
                if (rp) begin
                    o_next_state.right_down = 1'b1;
                end
                if (!lp && !rp) begin
                    lr = i_state.left_down;
                    rr = i_state.right_down;
                    o_next_state.left_down  = 1'b0;
                    o_next_state.right_down = 1'b0;
                end
                o_next_state.last_flags = '{right_release: rr, left_release: lr,
                                            right_press: rp, left_press: lp};
                o_next_state.pos = POS_HUNT;
            end
            default: begin
                o_next_state.pos = POS_HUNT;
                if (i_rx_byte[START_BIT]) begin
                    o_next_state.first_byte = i_rx_byte;
                    o_next_state.pos        = POS_SECOND;
                end
            end
        endcase
    end

    always_comb begin
        o_emit                  = 1'b0;
        o_report.kind           = KIND_PACKET;
        o_report.dx             = o_next_state.last_dx;
        o_report.dy             = o_next_state.last_dy;
        o_report.flags          = o_next_state.last_flags;
        o_report.middle_press   = 1'b0;
        o_report.middle_release = 1'b0;
        unique case (i_state.pos)
            POS_SECOND: begin
                o_emit = 1'b0;
            end
            POS_THIRD: begin
                o_emit = 1'b1;
            end
            default: begin
                if (i_rx_byte == MIDDLE_PRESS_BYTE) begin
                    o_emit                = 1'b1;
                    o_report.kind         = KIND_MIDDLE;
                    o_report.middle_press = 1'b1;
                end else if (i_rx_byte == MIDDLE_RELEASE_BYTE) begin
                    o_emit                  = 1'b1;
                    o_report.kind           = KIND_MIDDLE;
                    o_report.middle_release = 1'b1;
                end
            end
        endcase
    end

endmodule

@@ src/serial_mouse_packet_decoder_top.sv @@
// Serial mouse packet decoder: each report word is registered and appears in the cycle after its byte is accepted.
// Throughput one byte per cycle while o_in_stall is low; o_in_stall rises only while a held report is stalled.
// Synchronous active-low reset returns to hunting with cleared button and motion history.
// File: top level; instantiates smpd_decode, uses smpd_pkg.
module serial_mouse_packet_decoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_report_kind,
    output logic signed [7:0] o_dx,
    output logic signed [7:0] o_dy,
    output logic              o_left_press,
    output logic              o_right_press,
    output logic              o_left_release,
    output logic              o_right_release,
    output logic              o_middle_press,
    output logic              o_middle_release
);
    import smpd_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_report r_out;
    t_report dec_report;
    logic    r_out_valid;
    logic    dec_emit;
    logic    in_accept;

    smpd_decode u_decode (
        .i_rx_byte    (i_rx_byte),
        .i_state      (r_state),
        .o_next_state (n_state),
        .o_emit       (dec_emit),
        .o_report     (dec_report)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept && dec_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && dec_emit) begin
            r_out <= dec_report;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_report_kind    = r_out.kind;
    assign o_dx             = r_out.dx;
    assign o_dy             = r_out.dy;
    assign o_left_press     = r_out.flags.left_press;
    assign o_right_press    = r_out.flags.right_press;
    assign o_left_release   = r_out.flags.left_release;
    assign o_right_release  = r_out.flags.right_release;
    assign o_middle_press   = r_out.middle_press;
    assign o_middle_release = r_out.middle_release;

endmodule

@@ src/smpd_checker.sv @@
// Port-level checks for the serial mouse packet decoder, bound to the top level.
// Uses smpd_pkg for the report kind codes.
module smpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_report_kind,
    input logic [7:0] o_dx,
    input logic [7:0] o_dy,
    input logic       o_left_press,
    input logic       o_right_press,
    input logic       o_left_release,
    input logic       o_right_release,
    input logic       o_middle_press,
    input logic       o_middle_release
);
    import smpd_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dx) && $stable(o_dy)
            && $stable(o_report_kind))
        else $error("stalled report word changed");

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked report word");

    a_middle_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_kind == KIND_MIDDLE |-> o_middle_press != o_middle_release)
        else $error("middle report without exactly one middle flag");

    a_packet_no_middle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_kind == KIND_PACKET |-> !o_middle_press && !o_middle_release)
        else $error("packet report carries a middle flag");

    a_press_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_left_press || o_right_press) |-> !o_left_release && !o_right_release)
        else $error("release flagged together with a press");

endmodule

bind serial_mouse_packet_decoder_top smpd_checker u_smpd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_report_kind    (o_report_kind),
    .o_dx             (o_dx),
    .o_dy             (o_dy),
    .o_left_press     (o_left_press),
    .o_right_press    (o_right_press),
    .o_left_release   (o_left_release),
    .o_right_release  (o_right_release),
    .o_middle_press   (o_middle_press),
    .o_middle_release (o_middle_release)
);

@@ test/tb_serial_mouse_packet_decoder_top.sv @@
// Self-checking testbench for serial_mouse_packet_decoder_top: feeds received mouse bytes and
// compares each report word against a directed table or an in-bench decoder model kept in step with the DUT.
// Depends on smpd_pkg and the decoder RTL only.
module tb_serial_mouse_packet_decoder_top;
    import smpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 517;
    localparam int NUM_ROWS = 26;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_report    want;
    } t_row;

    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'h20, 1'b1, '{KIND_MIDDLE, 8'h00, 8'h00, 4'b0000, 1'b1, 1'b0}},
        '{8'h00, 1'b1, '{KIND_MIDDLE, 8'h00, 8'h00, 4'b0000, 1'b0, 1'b1}},
        '{8'h9F, 1'b0, '0},
        '{8'h7F, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{KIND_PACKET, 8'hFF, 8'hFF, 4'b0011, 1'b0, 1'b0}},
        '{8'h20, 1'b1, '{KIND_MIDDLE, 8'hFF, 8'hFF, 4'b0011, 1'b1, 1'b0}},
        '{8'hC0, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_PACKET, 8'h00, 8'h00, 4'b1100, 1'b0, 1'b0}},
        '{8'h00, 1'b1, '{KIND_MIDDLE, 8'h00, 8'h00, 4'b1100, 1'b0, 1'b1}},
        '{8'h40, 1'b0, '0},
        '{8'h20, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h62, 1'b0, '0},
        '{8'h15, 1'b0, '0},
        '{8'h2A, 1'b0, '0},
        '{8'h58, 1'b0, '0},
        '{8'hC0, 1'b0, '0},
        '{8'hBF, 1'b0, '0},
        '{8'h41, 1'b0, '0},
        '{8'h3F, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hCA, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_PACKET, 8'h80, 8'h80, 4'b0000, 1'b0, 1'b0}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_rx_byte = 8'h00;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_report_kind;
    logic signed [7:0] o_dx;
    logic signed [7:0] o_dy;
    logic              o_left_press;
    logic              o_right_press;
    logic              o_left_release;
    logic              o_right_release;
    logic              o_middle_press;
    logic              o_middle_release;

    serial_mouse_packet_decoder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_report_kind    (o_report_kind),
        .o_dx             (o_dx),
        .o_dy             (o_dy),
        .o_left_press     (o_left_press),
        .o_right_press    (o_right_press),
        .o_left_release   (o_left_release),
        .o_right_release  (o_right_release),
        .o_middle_press   (o_middle_press),
        .o_middle_release (o_middle_release)
    );

    t_pos       pkt_pos = POS_HUNT;
    logic [7:0] start_byte = 8'h00;
    logic [5:0] second_low = 6'h00;
    logic       left_held = 1'b0;
    logic       right_held = 1'b0;
    logic [7:0] prev_dx = 8'h00;
    logic [7:0] prev_dy = 8'h00;
    t_flags     prev_flags = '0;

    t_report report_q [$];
    int      errors = 0;
    int      items_sent = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 19;
    int      recv_stall_pct = 77;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic decode_mouse_byte(input logic [7:0] b, output logic has_report,
                                     output t_report rep);
        logic lp;
        logic rp;
        has_report = 1'b0;
        rep = '0;
        lp = start_byte[LEFT_BIT];
        rp = start_byte[RIGHT_BIT];
        case (pkt_pos)
            POS_SECOND: begin
                second_low = b[5:0];
                pkt_pos = POS_THIRD;
            end
            POS_THIRD: begin
                prev_dx = {start_byte[1:0], second_low};
                prev_dy = {start_byte[3:2], b[5:0]};
                prev_flags = '0;
                prev_flags.left_press = lp;
                prev_flags.right_press = rp;
                if (lp) left_held = 1'b1;
                if (rp) right_held = 1'b1;
                if (!lp && !rp) begin
                    prev_flags.left_release = left_held;
                    prev_flags.right_release = right_held;
                    left_held = 1'b0;
                    right_held = 1'b0;
                end
                pkt_pos = POS_HUNT;
                has_report = 1'b1;
                rep = '{KIND_PACKET, prev_dx, prev_dy, prev_flags, 1'b0, 1'b0};
            end
            default: begin
                pkt_pos = POS_HUNT;
                if (b == MIDDLE_PRESS_BYTE || b == MIDDLE_RELEASE_BYTE) begin
                    has_report = 1'b1;
                    rep = '{KIND_MIDDLE, prev_dx, prev_dy, prev_flags,
                            b == MIDDLE_PRESS_BYTE, b == MIDDLE_RELEASE_BYTE};
                end else if (b[START_BIT]) begin
                    start_byte = b;
                    pkt_pos = POS_SECOND;
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input t_report want = '0);
        logic    has_report;
        logic    was_hunting;
        t_report rep;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_rx_byte <= 8'($urandom_range(255));
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        was_hunting = (pkt_pos != POS_SECOND && pkt_pos != POS_THIRD);
        decode_mouse_byte(b, has_report, rep);
        if (has_report) report_q.push_back(typed ? want : rep);
        if (!(was_hunting && !has_report && pkt_pos == POS_HUNT)) items_sent++;
    endtask

    task automatic send_random_event();
        int         pick;
        logic [7:0] lead;
        pick = $urandom_range(99);
        lead = 8'($urandom_range(255));
        if (pick < 65) begin
            send_byte(lead | 8'h40);
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
        end else if (pick < 80) begin
            send_byte($urandom_range(1) ? MIDDLE_PRESS_BYTE : MIDDLE_RELEASE_BYTE);
        end else if (pick < 88) begin
            send_byte(lead | 8'h40);
            send_byte($urandom_range(1) ? MIDDLE_PRESS_BYTE : MIDDLE_RELEASE_BYTE);
            send_byte($urandom_range(1) ? MIDDLE_PRESS_BYTE : MIDDLE_RELEASE_BYTE);
        end else begin
            send_byte(lead);
        end
    endtask

    task automatic drain_reports();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
        if (got === want) return 0;
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        return 1;
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind = o_report_kind;
            got.dx = o_dx;
            got.dy = o_dy;
            got.flags.left_press = o_left_press;
            got.flags.right_press = o_right_press;
            got.flags.left_release = o_left_release;
            got.flags.right_release = o_right_release;
            got.middle_press = o_middle_press;
            got.middle_release = o_middle_release;
            if (report_q.size() == 0) begin
                $display("%0t: report word with none pending, expected nothing got %h",
                         $time, got);
                errors++;
            end else begin
                want = report_q.pop_front();
                errors += field_diff("report_kind", 8'(want.kind), 8'(got.kind));
                errors += field_diff("dx", want.dx, got.dx);
                errors += field_diff("dy", want.dy, got.dy);
                errors += field_diff("left_press", 8'(want.flags.left_press),
                                     8'(got.flags.left_press));
                errors += field_diff("right_press", 8'(want.flags.right_press),
                                     8'(got.flags.right_press));
                errors += field_diff("left_release", 8'(want.flags.left_release),
                                     8'(got.flags.left_release));
                errors += field_diff("right_release", 8'(want.flags.right_release),
                                     8'(got.flags.right_release));
                errors += field_diff("middle_press", 8'(want.middle_press),
                                     8'(got.middle_press));
                errors += field_diff("middle_release", 8'(want.middle_release),
                                     8'(got.middle_release));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 77 : 0;
            recv_stall_pct = (ph == 0) ? 77 : (ph == 1) ? 19 : 0;
            if (ph == 0) begin
                for (int r = 0; r < NUM_ROWS; r++) begin
                    send_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].typed,
                              DIRECTED_ROWS[r].want);
                end
            end
            while (items_sent < ITEMS_PER_PHASE * (ph + 1)) send_random_event();
            drain_reports();
        end
        repeat (8) @(posedge i_clk);
        if (errors == 0 && report_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/smpd_pkg.sv
src/smpd_decode.sv
src/serial_mouse_packet_decoder_top.sv
src/smpd_checker.sv
test/tb_serial_mouse_packet_decoder_top.sv
